// ===== rtl/evl_pkg.sv =====
// shared types, constants and ring index helpers for the event log ring
// no dependencies
`timescale 1ns / 1ps

package evl_pkg;

	localparam int LOG_SLOTS      = 256;
	localparam int THREAD_ID_BITS = 16;
	localparam int IDX_W          = $clog2(LOG_SLOTS);
	localparam int TID_W          = THREAD_ID_BITS;
	localparam int SIZE_W         = 8;
	localparam int CFG_W          = 32;

	localparam logic [7:0] LOST_FLAG = 8'h01;
	localparam logic [7:0] WAIT_FLAG = 8'h02;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [TID_W-1:0] tid_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_SWITCH = 2'd1,
		OP_READ   = 2'd2,
		OP_SCRUB  = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		REG_LOG_EN     = 2'd0,
		REG_LOG_SIZE   = 2'd1,
		REG_USER_STATE = 2'd2,
		REG_SIGMA      = 2'd3
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOST_WR,
		ST_SCRUB_RD,
		ST_SCRUB_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               logging_enable;
		logic [SIZE_W-1:0]  log_size;
		logic [31:0]        user_state;
		tid_t               sigma_id;
	} cfg_t;

	typedef struct packed {
		op_e         opcode;
		logic [7:0]  event_type;
		logic [7:0]  event_flags;
		tid_t        prev_id;
		tid_t        next_id;
		logic        prev_loggable;
		logic        next_loggable;
		logic        prev_waiting;
		logic [31:0] event_time;
		tid_t        exit_thread_id;
	} item_t;

	typedef struct packed {
		logic [7:0] ev_type;
		logic [7:0] flags;
		tid_t       prev;
		tid_t       next;
	} meta_t;

	typedef struct packed {
		logic [31:0] user_state;
		logic [31:0] ev_time;
	} stamp_t;

	typedef struct packed {
		logic        done_res;
		logic [7:0]  rec_type;
		logic [7:0]  rec_flags;
		logic [31:0] rec_user_state;
		logic [31:0] rec_time;
		tid_t        rec_prev;
		tid_t        rec_next;
	} res_t;

	// highest usable slot index, log size clipped to the store
	function automatic idx_t ring_last(logic [SIZE_W-1:0] sz);
		if (int'(sz) > LOG_SLOTS - 1)
			return idx_t'(LOG_SLOTS - 1);
		return idx_t'(sz);
	endfunction

	function automatic idx_t ring_next(idx_t i, idx_t last);
		if (i >= last)
			return '0;
		return idx_t'(i + 1'b1);
	endfunction

endpackage

// ===== rtl/evl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module evl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/evl_ctrl.sv =====
// sequencer for the event log: ring indices, record store, lost flag
// read-modify-write, oldest record read and thread scrub walk; uses evl_pkg, evl_ram
`timescale 1ns / 1ps

module evl_ctrl
	import evl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  cfg_clr,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	state_t state_q, state_d;
	idx_t   wr_idx_q, wr_idx_d;
	idx_t   rd_idx_q, rd_idx_d;
	idx_t   scan_q, scan_d;
	item_t  item_q;
	logic   done_q, done_d;
	logic   from_ram_q, from_ram_d;
	logic   fwd_q, fwd_d;
	meta_t  wmeta_q, wmeta_d;

	logic   meta_we, stamp_we, mem_re;
	idx_t   meta_waddr, mem_raddr;
	meta_t  meta_wdata, meta_rdata, lost_meta, scrub_meta, rec_meta;
	stamp_t stamp_wdata, stamp_rdata;

	idx_t   last, wn, wnn, rn, sn;
	logic   have_log, store_ok;
	tid_t   p_sel, n_sel;

	evl_ram #(.WIDTH($bits(meta_t)), .DEPTH(LOG_SLOTS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (meta_rdata)
	);

	evl_ram #(.WIDTH($bits(stamp_t)), .DEPTH(LOG_SLOTS)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (wr_idx_q),
		.wdata (stamp_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (stamp_rdata)
	);

	always_comb begin
		last     = ring_last(cfg.log_size);
		have_log = (cfg.log_size != '0);
		wn       = ring_next(wr_idx_q, last);
		wnn      = ring_next(wn, last);
		rn       = ring_next(rd_idx_q, last);
		sn       = ring_next(scan_q, last);
		p_sel    = item_q.prev_loggable ? item_q.prev_id : cfg.sigma_id;
		n_sel    = item_q.next_loggable ? item_q.next_id : cfg.sigma_id;

		if (item_q.opcode == OP_ADD) begin
			rec_meta.ev_type = item_q.event_type;
			rec_meta.flags   = item_q.event_flags;
			rec_meta.prev    = item_q.prev_id;
			rec_meta.next    = item_q.next_id;
			store_ok         = have_log;
		end else begin
			rec_meta.ev_type = '0;
			rec_meta.flags   = item_q.prev_waiting ? WAIT_FLAG : '0;
			rec_meta.prev    = p_sel;
			rec_meta.next    = n_sel;
			store_ok         = have_log && cfg.logging_enable && (p_sel != n_sel);
		end

		// two-slot-ring case (log size 1): the entry to flag is the one just written
		lost_meta       = fwd_q ? wmeta_q : meta_rdata;
		lost_meta.flags = lost_meta.flags | LOST_FLAG;

		scrub_meta = meta_rdata;
		if (meta_rdata.prev == item_q.exit_thread_id)
			scrub_meta.prev = cfg.sigma_id;
		if (meta_rdata.next == item_q.exit_thread_id)
			scrub_meta.next = cfg.sigma_id;

		stamp_wdata.user_state = cfg.user_state;
		stamp_wdata.ev_time    = item_q.event_time;
	end

	always_comb begin
		state_d    = state_q;
		wr_idx_d   = wr_idx_q;
		rd_idx_d   = rd_idx_q;
		scan_d     = scan_q;
		done_d     = done_q;
		from_ram_d = from_ram_q;
		fwd_d      = fwd_q;
		wmeta_d    = wmeta_q;
		meta_we    = 1'b0;
		stamp_we   = 1'b0;
		meta_waddr = wr_idx_q;
		meta_wdata = rec_meta;
		mem_re     = 1'b0;
		mem_raddr  = rd_idx_q;
		item_ready = 1'b0;
		res_valid  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				done_d     = 1'b0;
				from_ram_d = 1'b0;
				state_d    = ST_FINISH;
				case (item_q.opcode)
					OP_ADD, OP_SWITCH: begin
						if (store_ok) begin
							meta_we  = 1'b1;
							stamp_we = 1'b1;
							wmeta_d  = rec_meta;
							done_d   = 1'b1;
							wr_idx_d = wn;
							if (wn == rd_idx_q) begin
								rd_idx_d  = wnn;
								mem_re    = 1'b1;
								mem_raddr = wnn;
								fwd_d     = (wnn == wr_idx_q);
								state_d   = ST_LOST_WR;
							end
						end
					end
					OP_READ: begin
						if (have_log && rd_idx_q != wr_idx_q) begin
							mem_re     = 1'b1;
							mem_raddr  = rd_idx_q;
							rd_idx_d   = rn;
							done_d     = 1'b1;
							from_ram_d = 1'b1;
						end
					end
					OP_SCRUB: begin
						if (have_log) begin
							done_d = 1'b1;
							if (rd_idx_q != wr_idx_q) begin
								scan_d  = rd_idx_q;
								state_d = ST_SCRUB_RD;
							end
						end
					end
					default: ;
				endcase
			end
			ST_LOST_WR: begin
				meta_we    = 1'b1;
				meta_waddr = rd_idx_q;
				meta_wdata = lost_meta;
				state_d    = ST_FINISH;
			end
			ST_SCRUB_RD: begin
				mem_re    = 1'b1;
				mem_raddr = scan_q;
				state_d   = ST_SCRUB_WR;
			end
			ST_SCRUB_WR: begin
				meta_we    = 1'b1;
				meta_waddr = scan_q;
				meta_wdata = scrub_meta;
				scan_d     = sn;
				state_d    = (sn == wr_idx_q) ? ST_FINISH : ST_SCRUB_RD;
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					item_ready = 1'b1;
					state_d    = item_valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			done_q     <= 1'b0;
			from_ram_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			from_ram_q <= from_ram_d;
			fwd_q      <= fwd_d;
			if (cfg_clr) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_d;
				rd_idx_q <= rd_idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q  <= scan_d;
		wmeta_q <= wmeta_d;
		if (item_valid && item_ready)
			item_q <= item;
	end

	always_comb begin
		res = '0;
		res.done_res = done_q;
		if (from_ram_q) begin
			res.rec_type       = meta_rdata.ev_type;
			res.rec_flags      = meta_rdata.flags;
			res.rec_user_state = stamp_rdata.user_state;
			res.rec_time       = stamp_rdata.ev_time;
			res.rec_prev       = meta_rdata.prev;
			res.rec_next       = meta_rdata.next;
		end
	end

endmodule

// ===== rtl/task_event_log_ring_top.sv =====
// Overwriting ring-buffer event log. Items arrive on the s_ stream (opcode in s_tuser) and
// each gives exactly one result on the m_ stream (done flag in m_tuser). One item is worked
// on at a time; the block runs from two memories with one write and one registered read
// port each. When an add or task switch finds the log full, the lost flag is set on the
// new oldest record by a read-modify-write; a scrub walks every stored record with one
// memory read and one write back each. The memories are not cleared after reset: only
// records written since the log was last emptied are ever read. Writing log_size empties
// the log.
// uses evl_pkg, evl_ctrl
`timescale 1ns / 1ps

module task_event_log_ring_top
	import evl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// event_type, event_flags, prev_id, next_id, prev_loggable, next_loggable,
	// prev_waiting, event_time, exit_thread_id, zero pad
	input  logic [103:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rec_type, rec_flags, rec_user_state, rec_time, rec_prev, rec_next
	output logic [111:0] m_tdata,
	// done_res
	output logic [0:0]   m_tuser
);

	cfg_t  cfg_q;
	logic  cfg_clr;
	item_t item;
	res_t  res, out_q;
	logic  res_valid, res_ready, out_valid_q;
	logic  pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_LOG_EN:     cfg_q.logging_enable <= cfg_data[0];
				REG_LOG_SIZE:   cfg_q.log_size       <= cfg_data[SIZE_W-1:0];
				REG_USER_STATE: cfg_q.user_state     <= cfg_data;
				REG_SIGMA:      cfg_q.sigma_id       <= cfg_data[TID_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_clr = cfg_we && (cfg_reg_e'(cfg_index) == REG_LOG_SIZE);

	always_comb begin
		item.opcode         = op_e'(s_tuser);
		item.event_type     = s_tdata[7:0];
		item.event_flags    = s_tdata[15:8];
		item.prev_id        = s_tdata[31:16];
		item.next_id        = s_tdata[47:32];
		item.prev_loggable  = s_tdata[48];
		item.next_loggable  = s_tdata[49];
		item.prev_waiting   = s_tdata[50];
		item.event_time     = s_tdata[82:51];
		item.exit_thread_id = s_tdata[98:83];
	end

	evl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_clr    (cfg_clr),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register parts the result from the next item
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (res_ready)
				out_valid_q <= res_valid;
			if (s_tvalid && s_tready)
				pend_q <= 1'b1;
			else if (res_valid && res_ready)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.done_res;
	assign m_tdata  = {out_q.rec_next, out_q.rec_prev, out_q.rec_time,
		out_q.rec_user_state, out_q.rec_flags, out_q.rec_type};

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !pend_q || (res_valid && res_ready))
		else $error("item accepted before previous result was handed over");

	a_no_orphan_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q)
		else $error("result offered without an accepted item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !res_valid)
		else $error("block ready again right after accepting an item");

	a_zero_when_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("record fields set on a result that did not complete");

endmodule
